[rtl/sqmd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqmd_pkg
// Shared types and codes for the sorted queue merge/dedup block.
// ----------------------------------------------------------------------------
package sqmd_pkg;

  localparam int VALUE_W = 32;

  // Request kinds carried on the input tuser
  typedef enum logic [1:0] {
    ACT_PUSH_A = 2'd0,
    ACT_PUSH_B = 2'd1,
    ACT_MERGE  = 2'd2
  } action_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_DRAIN
  } state_t;

  // Commands from the sequencer to one queue
  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctl_t;

  // Status from one queue back to the sequencer
  typedef struct packed {
    logic empty;
    logic full;
    logic tail_hit;
  } queue_stat_t;

endpackage

[rtl/sqmd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqmd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sqmd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/sqmd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqmd_queue
// One bounded FIFO of values: ring pointers, tail copy for the repeat check,
// and a RAM holding the entries. The head entry is always being read.
// ----------------------------------------------------------------------------
module sqmd_queue #(
  parameter int DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sqmd_pkg::queue_ctl_t           ctl,
  input  logic [sqmd_pkg::VALUE_W-1:0]   push_value,
  output sqmd_pkg::queue_stat_t          stat,
  output logic [sqmd_pkg::VALUE_W-1:0]   head_value
);

  import sqmd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  logic [AW-1:0]      head;
  logic [AW-1:0]      head_next;
  logic [AW-1:0]      head_inc;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [VALUE_W-1:0] tail;
  logic [SW-1:0]      wr_sum;
  logic [SW-1:0]      wr_wrap;
  logic [AW-1:0]      wr_addr;
  logic               wr_en;

  // Status toward the sequencer
  assign stat.empty    = (count == '0);
  assign stat.full     = (count == CW'(DEPTH));
  assign stat.tail_hit = (count != '0) && (tail == push_value);

  // Tail slot: head plus count, wrapped once
  assign wr_sum  = SW'(head) + SW'(count);
  assign wr_wrap = (wr_sum >= SW'(DEPTH)) ? (wr_sum - SW'(DEPTH)) : wr_sum;
  assign wr_addr = wr_wrap[AW-1:0];

  // Store only new, non-repeated values into a queue with room
  assign wr_en = ctl.push && !stat.tail_hit && !stat.full;

  // Advance the head pointer on a pop
  assign head_inc  = (head == AW'(DEPTH - 1)) ? '0 : (head + AW'(1));
  assign head_next = ctl.pop ? head_inc : head;

  always_comb begin
    count_next = count;
    if (wr_en) begin
      count_next = count + CW'(1);
    end else if (ctl.pop) begin
      count_next = count - CW'(1);
    end
  end

  // Pointer state
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // Keep a copy of the newest entry for the repeat check
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tail <= push_value;
    end
  end

  // Entry storage; read address follows the next head so data is ready
  sqmd_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (push_value),
    .rd_addr (head_next),
    .rd_data (head_value)
  );

endmodule

[rtl/sorted_queue_merge_dedup_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_queue_merge_dedup_top
// Two value queues loaded by push requests and drained by a merge request
// into one ordered stream without repeats.
//
//   channel  dir  tdata              tuser          tlast
//   s_axis   in   [31:0] value       [1:0] action   -
//   m_axis   out  [31:0] merged val  [0] overflow   last of merge
//
// A push is taken only while idle. A merge primes the RAM read in ST_PRIME,
// then pops the heads step by step in ST_DRAIN (equal heads pop together), and
// finally flushes the held value with the last mark. No new request is taken
// during a merge. Output stalls hold the drain in place, though a repeat of the
// held value is still dropped. Reset empties both queues and clears the
// overflow flag; queue RAM contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_queue_merge_dedup_top #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] merged_value
  output logic [0:0]  m_axis_tuser,   // [0] overflow
  output logic        m_axis_tlast
);

  import sqmd_pkg::*;

  state_t             state;
  state_t             state_next;
  queue_ctl_t         ctl_a;
  queue_ctl_t         ctl_b;
  queue_stat_t        stat_a;
  queue_stat_t        stat_b;
  logic [VALUE_W-1:0] head_a;
  logic [VALUE_W-1:0] head_b;

  logic               overflow;
  logic               overflow_next;
  logic               pend_valid;
  logic               pend_valid_next;
  logic [VALUE_W-1:0] pend_value;
  logic [VALUE_W-1:0] pend_value_next;
  logic               out_valid;
  logic [VALUE_W-1:0] out_value;
  logic               out_last;
  logic               out_ovf;
  logic               out_load;
  logic [VALUE_W-1:0] out_load_value;
  logic               out_load_last;

  logic               slot_free;
  logic               take_a;
  logic               take_b;
  logic               a_lt_b;
  logic               b_lt_a;
  logic               dup;
  logic [VALUE_W-1:0] pick;

  assign slot_free = !out_valid || m_axis_tready;

  // Head comparison and pick selection
  assign a_lt_b = $signed(head_a) < $signed(head_b);
  assign b_lt_a = $signed(head_b) < $signed(head_a);
  assign take_a = !stat_a.empty && (stat_b.empty || !b_lt_a);
  assign take_b = !stat_b.empty && (stat_a.empty || !a_lt_b);
  assign pick   = take_a ? head_a : head_b;
  assign dup    = pend_valid && (pick == pend_value);

  // Sequencer: next state and queue commands
  always_comb begin
    state_next      = state;
    s_axis_tready   = 1'b0;
    ctl_a           = '0;
    ctl_b           = '0;
    overflow_next   = overflow;
    pend_valid_next = pend_valid;
    pend_value_next = pend_value;
    out_load        = 1'b0;
    out_load_value  = pend_value;
    out_load_last   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          case (s_axis_tuser)
            ACT_PUSH_A: begin
              ctl_a.push    = 1'b1;
              overflow_next = overflow || (stat_a.full && !stat_a.tail_hit);
            end
            ACT_PUSH_B: begin
              ctl_b.push    = 1'b1;
              overflow_next = overflow || (stat_b.full && !stat_b.tail_hit);
            end
            ACT_MERGE: begin
              state_next      = ST_PRIME;
              pend_valid_next = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PRIME: begin
        // Wait for the head reads
        state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (stat_a.empty && stat_b.empty) begin
          // Flush the held value with the last mark, then finish
          if (!pend_valid) begin
            overflow_next = 1'b0;
            state_next    = ST_IDLE;
          end else if (slot_free) begin
            out_load        = 1'b1;
            out_load_last   = 1'b1;
            pend_valid_next = 1'b0;
            overflow_next   = 1'b0;
            state_next      = ST_IDLE;
          end
        end else if (dup) begin
          // Drop a repeat of the value just taken
          ctl_a.pop = take_a;
          ctl_b.pop = take_b;
        end else if (slot_free) begin
          // Send the held value and hold the new pick
          ctl_a.pop       = take_a;
          ctl_b.pop       = take_b;
          out_load        = pend_valid;
          pend_valid_next = 1'b1;
          pend_value_next = pick;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      overflow   <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      overflow   <= overflow_next;
      pend_valid <= pend_valid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_value <= pend_value_next;
    if (out_load) begin
      out_value <= out_load_value;
      out_last  <= out_load_last;
      out_ovf   <= overflow;
    end
  end

  // Queues
  sqmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_a (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl_a),
    .push_value (s_axis_tdata),
    .stat       (stat_a),
    .head_value (head_a)
  );

  sqmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_b (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl_b),
    .push_value (s_axis_tdata),
    .stat       (stat_b),
    .head_value (head_b)
  );

  // Result port
  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_value;
  assign m_axis_tlast    = out_last;
  assign m_axis_tuser[0] = out_ovf;

endmodule

[tb/sv/sqmd_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqmd_tb_pkg
// Merge predictor and result scoreboard for the sorted queue merge/dedup
// block. It mirrors both queues and the sticky overflow flag, turns each
// accepted merge request into the list of results it must produce, and
// checks every accepted result against the oldest one still outstanding.
// ----------------------------------------------------------------------------
package sqmd_tb_pkg;

  import sqmd_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic        overflow;
  } merged_item_t;

  class merge_scoreboard;

    int             depth;
    logic [31:0]    list_a[$];
    logic [31:0]    list_b[$];
    logic           overflow_flag;
    merged_item_t   expected_q[$];
    int             error_count;
    int             request_count;
    int             merge_count;
    int             overflow_merges;
    int             result_count;
    int             tail_drops;
    int             full_drops;

    function new(int queue_depth = 32);
      depth = queue_depth;
      overflow_flag = 1'b0;
      error_count = 0;
      request_count = 0;
      merge_count = 0;
      overflow_merges = 0;
      result_count = 0;
      tail_drops = 0;
      full_drops = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Append to one queue; a repeat of the tail is dropped before the full test
    function void push_into(ref logic [31:0] q[$], input logic [31:0] val);
      if (q.size() > 0 && q[q.size() - 1] == val) begin
        tail_drops++;
        return;
      end
      if (q.size() >= depth) begin
        overflow_flag = 1'b1;
        full_drops++;
        return;
      end
      q.push_back(val);
    endfunction

    // Drain both queues in order, smaller head first, without repeats
    function void drain_queues();
      logic [31:0]  pick;
      logic [31:0]  prev;
      logic [31:0]  run[$];
      merged_item_t item;
      prev = '0;
      while (list_a.size() > 0 || list_b.size() > 0) begin
        if (list_a.size() == 0) begin
          pick = list_b.pop_front();
        end else if (list_b.size() == 0) begin
          pick = list_a.pop_front();
        end else if ($signed(list_a[0]) < $signed(list_b[0])) begin
          pick = list_a.pop_front();
        end else if ($signed(list_b[0]) < $signed(list_a[0])) begin
          pick = list_b.pop_front();
        end else begin
          // equal heads: keep one, discard the other
          pick = list_a.pop_front();
          void'(list_b.pop_front());
        end
        if (run.size() == 0 || pick != prev) begin
          run.push_back(pick);
        end
        prev = pick;
      end
      for (int i = 0; i < run.size(); i++) begin
        item.value = run[i];
        item.last = (i == run.size() - 1);
        item.overflow = overflow_flag;
        expected_q.push_back(item);
      end
      merge_count++;
      if (overflow_flag) begin
        overflow_merges++;
      end
      overflow_flag = 1'b0;
    endfunction

    // Note one accepted request
    function void note_request(logic [1:0] act, logic [31:0] val);
      case (action_t'(act))
        ACT_PUSH_A: push_into(list_a, val);
        ACT_PUSH_B: push_into(list_b, val);
        ACT_MERGE:  drain_queues();
        default: begin
          // unused code: no effect
        end
      endcase
      request_count++;
    endfunction

    // Check one accepted result against the oldest expectation
    function void check_result(logic [31:0] data, logic last, logic ovf);
      merged_item_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: merged_value %0d last %0b overflow %0b",
               $signed(data), last, ovf);
        error_count++;
        return;
      end
      want = expected_q.pop_front();
      result_count++;
      if (data !== want.value) begin
        $error("merged_value mismatch: expected %0d, actual %0d",
               $signed(want.value), $signed(data));
        error_count++;
      end
      if (last !== want.last) begin
        $error("last mismatch: expected %0b, actual %0b", want.last, last);
        error_count++;
      end
      if (ovf !== want.overflow) begin
        $error("overflow mismatch: expected %0b, actual %0b", want.overflow, ovf);
        error_count++;
      end
    endfunction

    // Anything still outstanding at the end never came out
    function void flag_leftovers();
      if (expected_q.size() > 0) begin
        $error("%0d expected results never arrived", expected_q.size());
        error_count += expected_q.size();
      end
    endfunction

  endclass

endpackage

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the sorted queue merge/dedup block. Push and merge
// requests go in through s_axis with random gaps; merged results are taken
// from m_axis under random back-pressure and checked one by one against a
// predictor that keeps its own copy of both queues and the overflow flag.
// ----------------------------------------------------------------------------
module tb_top;

  import sqmd_pkg::*;
  import sqmd_tb_pkg::*;

  localparam int          DEPTH        = 32;
  localparam int          RANDOM_ITEMS = 220;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          IDLE_LIMIT   = 4000;
  localparam int          DRAIN_CYCLES = 2 * DEPTH + 40;
  localparam logic [31:0] INT_MIN_V    = 32'h8000_0000;
  localparam logic [31:0] INT_MAX_V    = 32'h7FFF_FFFF;
  localparam logic [1:0]  ACT_UNUSED   = 2'd3;

  typedef enum int {
    SEQ_MIXED,
    SEQ_REPEATS,
    SEQ_FILL,
    SEQ_NOISE
  } seq_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = ACT_PUSH_A;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          items_sent = 0;
  bit          hold_req = 1'b0;
  int          hold_cnt;
  int          stall_cycles = 0;

  merge_scoreboard board = new(DEPTH);

  sorted_queue_merge_dedup_top #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: random stalls, or a long hold-off when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (hold_cnt = 1; hold_cnt < HOLD_CYCLES; hold_cnt++) begin
          @(negedge clk);
        end
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      board.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
    end
  end

  // Abort when nothing moves on either side for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Offer one request after a random gap; return at the accepting edge
  task automatic send_request(input logic [1:0] act, input logic [31:0] val);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= $urandom;
      s_axis_tuser <= 2'($urandom);
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= val;
    do @(posedge clk); while (!s_axis_tready);
    board.note_request(act, val);
    if (act != ACT_UNUSED) begin
      items_sent++;
    end
  endtask

  // Stop offering and wait until every expected result is out
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (board.pending() > 0) begin
      @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return INT_MIN_V;
      1:       return INT_MAX_V;
      2, 3:    return 32'($urandom_range(8)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  // One burst of pushes, usually closed by a merge
  task automatic run_sequence(input seq_kind_t kind);
    int          n;
    int          na;
    int          nb;
    logic [31:0] base;
    logic [31:0] val;
    logic [1:0]  act;
    val = '0;
    case (kind)
      SEQ_MIXED, SEQ_REPEATS: begin
        n = $urandom_range(kind == SEQ_MIXED ? 20 : 16);
        for (int i = 0; i < n; i++) begin
          act = $urandom_range(1) ? ACT_PUSH_B : ACT_PUSH_A;
          if (kind == SEQ_REPEATS) begin
            val = 32'($urandom_range(5));
          end else if (i == 0 || $urandom_range(4) != 0) begin
            val = pick_value();
          end
          send_request(act, val);
        end
        send_request(ACT_MERGE, $urandom);
      end
      SEQ_FILL: begin
        // disjoint ascending runs, often past the queue depth
        base = $urandom;
        na = $urandom_range(DEPTH + 2, DEPTH - 4);
        nb = $urandom_range(DEPTH + 2);
        for (int i = 0; i < na; i++) begin
          send_request(ACT_PUSH_A, base + 32'(2 * i));
        end
        for (int i = 0; i < nb; i++) begin
          send_request(ACT_PUSH_B, base + 32'(2 * i + 1));
        end
        // repeat of the tail, even into a full queue, must not flag overflow
        if ($urandom_range(1)) begin
          send_request(ACT_PUSH_A, base + 32'(2 * (na > DEPTH ? DEPTH : na) - 2));
        end
        send_request(ACT_MERGE, $urandom);
      end
      default: begin
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++) begin
          send_request(2'($urandom), pick_value());
        end
      end
    endcase
  endtask

  initial begin
    int        target;
    int        r;
    seq_kind_t kind;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Merge with both queues empty
    send_request(ACT_MERGE, 32'd0);

    // Extremes, repeat of the tail, equal heads, signed ordering
    send_request(ACT_PUSH_A, INT_MIN_V);
    send_request(ACT_PUSH_A, 32'hFFFF_FFFF);
    send_request(ACT_PUSH_A, 32'd0);
    send_request(ACT_PUSH_A, 32'd0);
    send_request(ACT_PUSH_A, INT_MAX_V);
    send_request(ACT_PUSH_B, INT_MIN_V);
    send_request(ACT_PUSH_B, 32'd5);
    send_request(ACT_PUSH_B, 32'd5);
    send_request(ACT_PUSH_B, 32'hFFFF_FFFF);
    send_request(ACT_PUSH_B, INT_MAX_V);
    send_request(ACT_UNUSED, 32'h5A5A_A5A5);
    send_request(ACT_MERGE, 32'hFFFF_FFFF);

    // Only one queue holds values
    send_request(ACT_PUSH_B, 32'd3);
    send_request(ACT_PUSH_B, 32'd3);
    send_request(ACT_MERGE, 32'd0);

    // Long result hold-off while requests keep coming
    send_request(ACT_PUSH_A, 32'd10);
    send_request(ACT_PUSH_A, 32'd30);
    send_request(ACT_PUSH_A, 32'd50);
    send_request(ACT_PUSH_B, 32'd20);
    send_request(ACT_PUSH_B, 32'd30);
    send_request(ACT_PUSH_B, 32'd40);
    hold_req = 1'b1;
    send_request(ACT_MERGE, 32'd0);
    send_request(ACT_PUSH_A, 32'd7);
    send_request(ACT_PUSH_B, 32'd8);
    send_request(ACT_MERGE, 32'd0);
    wait_drained();

    // Random part in four idling phases
    target = items_sent;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 51; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 51; end
        default: begin src_idle_pct = 36; sink_stall_pct = 36; end
      endcase
      target += RANDOM_ITEMS / 4;
      if (phase == 0) begin
        run_sequence(SEQ_FILL);
      end
      while (items_sent < target) begin
        r = $urandom_range(99);
        if (r < 58) kind = SEQ_MIXED;
        else if (r < 80) kind = SEQ_REPEATS;
        else if (r < 87) kind = SEQ_FILL;
        else kind = SEQ_NOISE;
        run_sequence(kind);
      end
      send_request(ACT_MERGE, $urandom);
      wait_drained();
    end

    // Let any stray result show up, then report
    repeat (DRAIN_CYCLES) @(negedge clk);
    board.flag_leftovers();
    $display("Run covered %0d requests and %0d merges (%0d with overflow set).",
             board.request_count, board.merge_count, board.overflow_merges);
    $display("Checked %0d results; pushes dropped: %0d tail repeats, %0d into full queues.",
             board.result_count, board.tail_drops, board.full_drops);
    if (board.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
rtl/sqmd_pkg.sv
rtl/sqmd_ram.sv
rtl/sqmd_queue.sv
rtl/sorted_queue_merge_dedup_top.sv
tb/sv/sqmd_tb_pkg.sv
tb/sv/tb_top.sv
